// File: rtl/lacb_pkg.sv
// Shared types, widths and rounding helper for the camera basis block.
package lacb_pkg;

    // Bits of the forward magnitude, 0 .. 2^30
    localparam int QW  = 31;
    // Number of normalizing cells, one per magnitude bit
    localparam int NCELL = QW;
    // Eye minus target difference width
    localparam int DW  = 33;
    // Squared difference and squared length width
    localparam int SQW = 66;
    // Slack term width (signed)
    localparam int EW  = 132;
    // Running t*S term width (signed)
    localparam int BW  = 100;
    // Output vector component width
    localparam int OW  = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAME = 2'd1,
        ST_VERT = 2'd2
    } t_status;

    // One forward component under normalization
    typedef struct packed {
        logic [QW-1:0]        q;
        logic signed [EW-1:0] e;
        logic signed [BW-1:0] b;
    } t_lane;

    // What moves from one cell to the next
    typedef struct packed {
        logic           v;
        t_status        st;
        logic [2:0]     neg;
        logic [SQW-1:0] s;
        t_lane [2:0]    ln;
    } t_cell;

    // Result beat
    typedef struct packed {
        logic signed [OW-1:0] rx;
        logic signed [OW-1:0] ry;
        logic signed [OW-1:0] rz;
        logic signed [OW-1:0] ux;
        logic signed [OW-1:0] uy;
        logic signed [OW-1:0] uz;
        logic signed [OW-1:0] fx;
        logic signed [OW-1:0] fy;
        logic signed [OW-1:0] fz;
        t_status              st;
    } t_res;

    // Q4.60 to Q2.30, nearest, ties away from zero
    function automatic logic signed [OW-1:0] rnd_q60(input logic signed [64:0] p);
        logic [64:0] m;
        logic [64:0] r;
        m = p[64] ? 65'(-p) : 65'(p);
        r = (m + 65'(1) * (65'(1) << 29)) >> 30;
        return p[64] ? -$signed(r[OW-1:0]) : $signed(r[OW-1:0]);
    endfunction

endpackage

// File: rtl/look_at_camera_basis.sv
// Camera basis (right, up, forward) from an eye point and a target point.
// Takes one eye/target pair per cycle while the skid entry is empty (o_ready high) and
// returns one basis beat per pair. The pipeline is the row of 31 normalizing cells, one
// per bit of the forward magnitude, plus three set-up stages and two for the up products
// and rounding. A two-entry output (register plus skid) lets input beats flow while a
// result waits. Inputs are signed Q16.16, vector outputs signed Q2.30; status 1 (eye equals
// target) or 2 (forward along vertical) returns all vectors as zero.
module look_at_camera_basis import lacb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_right_x,
    output logic signed [31:0] o_right_y,
    output logic signed [31:0] o_right_z,
    output logic signed [31:0] o_up_x,
    output logic signed [31:0] o_up_y,
    output logic signed [31:0] o_up_z,
    output logic signed [31:0] o_fwd_x,
    output logic signed [31:0] o_fwd_y,
    output logic signed [31:0] o_fwd_z,
    output logic [1:0]         o_basis_status
);

    logic                 en;
    logic signed [DW-1:0] d [3];
    logic [DW-1:0]        ad [3];
    t_status              st1;

    logic                 r1_v;
    logic [DW-1:0]        r1_ad [3];
    logic [2:0]           r1_neg;
    t_status              r1_st;

    logic                 r2_v;
    logic [SQW-1:0]       r2_sq [3];
    logic [2:0]           r2_neg;
    t_status              r2_st;

    logic                 r3_v;
    t_cell                r3_c;
    logic [SQW-1:0]       s_sum;

    t_cell                c [NCELL+1];

    logic signed [OW-1:0] f [3];
    logic                 r4_v;
    logic signed [OW-1:0] r4_f [3];
    logic signed [63:0]   r4_p01;
    logic signed [63:0]   r4_p00;
    logic signed [63:0]   r4_p22;
    logic signed [63:0]   r4_p12;
    t_status              r4_st;

    t_res                 res;
    t_res                 r_out;
    t_res                 r_skid;
    logic                 r_out_v;
    logic                 r_skid_v;

    // Pipeline moves unless the skid entry is occupied
    assign en      = !r_skid_v;
    assign o_ready = en;

    // Stage 1: exact differences and classification
    always_comb begin
        d[0] = {i_eye_x[31], i_eye_x} - {i_target_x[31], i_target_x};
        d[1] = {i_eye_y[31], i_eye_y} - {i_target_y[31], i_target_y};
        d[2] = {i_eye_z[31], i_eye_z} - {i_target_z[31], i_target_z};
        for (int k = 0; k < 3; k++) begin
            ad[k] = d[k][DW-1] ? DW'(-d[k]) : DW'(d[k]);
        end
        if (d[0] == '0 && d[1] == '0 && d[2] == '0) begin
            st1 = ST_SAME;
        end else if (d[0] == '0 && d[2] == '0) begin
            st1 = ST_VERT;
        end else begin
            st1 = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= c[NCELL].v;
        end
    end

    // Stages 1 to 3 payload: squares, then squared length and cell seed
    assign s_sum = r2_sq[0] + r2_sq[1] + r2_sq[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ad[k]  <= ad[k];
                r1_neg[k] <= d[k][DW-1];
                r2_sq[k]  <= SQW'(r1_ad[k]) * SQW'(r1_ad[k]);
                r3_c.ln[k].q <= '0;
                r3_c.ln[k].e <= $signed({{(EW-SQW-62){1'b0}}, r2_sq[k], 62'b0})
                              - $signed({{(EW-SQW){1'b0}}, s_sum});
                r3_c.ln[k].b <= -$signed({{(BW-SQW){1'b0}}, s_sum});
            end
            r1_st     <= st1;
            r2_neg    <= r1_neg;
            r2_st     <= r1_st;
            r3_c.neg  <= r2_neg;
            r3_c.st   <= r2_st;
            r3_c.s    <= s_sum;
            r3_c.v    <= 1'b0;
        end
    end

    always_comb begin
        c[0]   = r3_c;
        c[0].v = r3_v;
    end

    // Row of cells, most significant magnitude bit first
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        lacb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (5'(NCELL - 1 - g)),
            .i_c     (c[g]),
            .o_c     (c[g+1])
        );
    end

    // Signed forward and the up products
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            f[k] = $signed({1'b0, c[NCELL].ln[k].q});
            if (c[NCELL].neg[k]) begin
                f[k] = -f[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r4_f[k] <= f[k];
            end
            r4_p01 <= f[0] * f[1];
            r4_p00 <= f[0] * f[0];
            r4_p22 <= f[2] * f[2];
            r4_p12 <= f[1] * f[2];
            r4_st  <= c[NCELL].st;
        end
    end

    // Rounding and degenerate-case masking
    always_comb begin
        res    = '0;
        res.st = r4_st;
        if (r4_st == ST_OK) begin
            res.rx = r4_f[2];
            res.rz = -r4_f[0];
            res.ux = rnd_q60(-65'(r4_p01));
            res.uy = rnd_q60(65'(r4_p00) + 65'(r4_p22));
            res.uz = rnd_q60(-65'(r4_p12));
            res.fx = r4_f[0];
            res.fy = r4_f[1];
            res.fz = r4_f[2];
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= r4_v;
            end
        end else if (r4_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_ready) begin
            r_out <= r_skid_v ? r_skid : res;
        end
        if (en) begin
            r_skid <= res;
        end
    end

    assign o_valid        = r_out_v;
    assign o_right_x      = r_out.rx;
    assign o_right_y      = r_out.ry;
    assign o_right_z      = r_out.rz;
    assign o_up_x         = r_out.ux;
    assign o_up_y         = r_out.uy;
    assign o_up_z         = r_out.uz;
    assign o_fwd_x        = r_out.fx;
    assign o_fwd_y        = r_out.fy;
    assign o_fwd_z        = r_out.fz;
    assign o_basis_status = r_out.st;

endmodule

// File: rtl/lacb_cell.sv
// One normalizing cell: decides one magnitude bit for all three forward lanes.
module lacb_cell import lacb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [4:0]  i_bit,
    input  t_cell       i_c,
    output t_cell       o_c
);

    t_cell                r_c;
    logic                 r_v;
    t_cell                n_c;
    logic signed [BW-1:0] sb;
    logic signed [BW-1:0] d  [3];
    logic signed [EW-1:0] dl [3];
    logic signed [EW-1:0] e2 [3];

    // Try setting this bit: t grows by 2^(bit+1), t^2*S grows by 2^(bit+2)*(B + S*2^bit)
    always_comb begin
        n_c = i_c;
        sb  = $signed({{(BW-SQW){1'b0}}, i_c.s}) <<< i_bit;
        for (int k = 0; k < 3; k++) begin
            d[k]  = i_c.ln[k].b + sb;
            dl[k] = EW'(d[k]) <<< (6'(i_bit) + 6'd2);
            e2[k] = i_c.ln[k].e - dl[k];
            if (!e2[k][EW-1]) begin
                n_c.ln[k].q[i_bit] = 1'b1;
                n_c.ln[k].e        = e2[k];
                n_c.ln[k].b        = d[k] + sb;
            end
        end
    end

    // Control bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_c.v;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= n_c;
        end
    end

    always_comb begin
        o_c   = r_c;
        o_c.v = r_v;
    end

endmodule

// File: rtl/lacb_checker.sv
// Port-level checks for the camera basis block, bound to the top level.
module lacb_checker import lacb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_right_x,
    input logic signed [31:0] o_right_y,
    input logic signed [31:0] o_fwd_x,
    input logic signed [31:0] o_fwd_y,
    input logic signed [31:0] o_fwd_z,
    input logic [1:0]         o_basis_status
);

    // Stalled result beat stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result beat dropped while stalled");

    // Status code 3 is never produced
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_basis_status != 2'd3)
        else $error("bad status code");

    // Right axis has no vertical part
    a_ry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_right_y == '0)
        else $error("right_y nonzero");

    // Degenerate cases give zero forward
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_basis_status != ST_OK |->
            o_fwd_x == '0 && o_fwd_y == '0 && o_fwd_z == '0)
        else $error("degenerate beat with nonzero forward");

    // Right x mirrors forward z
    a_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_right_x == o_fwd_z)
        else $error("right_x differs from fwd_z");

endmodule

bind look_at_camera_basis lacb_checker u_lacb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_right_x      (o_right_x),
    .o_right_y      (o_right_y),
    .o_fwd_x        (o_fwd_x),
    .o_fwd_y        (o_fwd_y),
    .o_fwd_z        (o_fwd_z),
    .o_basis_status (o_basis_status)
);

// File: tb/sv/tb_look_at_camera_basis.sv
// Self-checking testbench for the camera basis block.
`timescale 1ns / 100ps

module tb_look_at_camera_basis;
    import lacb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    logic signed [31:0] i_target_x = '0, i_target_y = '0, i_target_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_right_x, o_right_y, o_right_z;
    logic signed [31:0] o_up_x, o_up_y, o_up_z;
    logic signed [31:0] o_fwd_x, o_fwd_y, o_fwd_z;
    logic [1:0]         o_basis_status;

    t_res basis_q[$];
    int   n_errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   recv_hold = 0;
    int   quiet_cycles = 0;

    look_at_camera_basis dut (.*);

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Q4.60 to Q2.30, nearest, ties away from zero
    function automatic logic signed [31:0] round_q30(input logic signed [65:0] p);
        logic [65:0] m;
        m = p[65] ? -p : p;
        m = (m + (66'd1 << 29)) >> 30;
        return p[65] ? -$signed(m[31:0]) : $signed(m[31:0]);
    endfunction

    // Nearest q to ad * 2^30 / sqrt(s)
    function automatic logic [31:0] unit_mag(input logic [32:0] ad, input logic [66:0] s);
        logic [159:0] lo, hi, mid, t, rhs;
        lo  = 0;
        hi  = 160'd1 << 30;
        rhs = (160'(ad) * 160'(ad)) << 62;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            t   = 2 * mid - 1;
            if (t * t * 160'(s) <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[31:0];
    endfunction

    // Expected basis for one eye/target pair
    function automatic t_res camera_basis(input logic signed [31:0] ex, ey, ez, tx, ty, tz);
        t_res r;
        logic signed [32:0] d [3];
        logic [32:0] ad [3];
        logic [66:0] s;
        logic signed [65:0] f [3];
        logic [31:0] m;
        r = '0;
        d[0] = 33'(ex) - 33'(tx);
        d[1] = 33'(ey) - 33'(ty);
        d[2] = 33'(ez) - 33'(tz);
        for (int i = 0; i < 3; i++) ad[i] = d[i][32] ? -d[i] : d[i];
        if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            r.st = ST_SAME;
        end else if (d[0] == 0 && d[2] == 0) begin
            r.st = ST_VERT;
        end else begin
            r.st = ST_OK;
            s = 67'(ad[0]) * 67'(ad[0]) + 67'(ad[1]) * 67'(ad[1]) + 67'(ad[2]) * 67'(ad[2]);
            for (int i = 0; i < 3; i++) begin
                m = unit_mag(ad[i], s);
                f[i] = d[i][32] ? -66'(m) : 66'(m);
            end
            r.rx = f[2][31:0];
            r.ry = '0;
            r.rz = -f[0][31:0];
            r.ux = round_q30(-(f[0] * f[1]));
            r.uy = round_q30(f[0] * f[0] + f[2] * f[2]);
            r.uz = round_q30(-(f[1] * f[2]));
            r.fx = f[0][31:0];
            r.fy = f[1][31:0];
            r.fz = f[2][31:0];
        end
        return r;
    endfunction

    // Send one pair; optional idle gap first, then hold until accepted
    task automatic send_pair(input logic signed [31:0] ex, ey, ez, tx, ty, tz);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_eye_x    <= ex;
        i_eye_y    <= ey;
        i_eye_z    <= ez;
        i_target_x <= tx;
        i_target_y <= ty;
        i_target_z <= tz;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        basis_q.push_back(camera_basis(ex, ey, ez, tx, ty, tz));
    endtask

    function automatic logic signed [31:0] rand_coord(input int kind);
        case (kind)
            0: return $signed($urandom());
            1: return $signed(32'($urandom_range(2000)) - 32'd1000) <<< 8;
            default: return $signed(32'($urandom_range(131072)) - 32'd65536);
        endcase
    endfunction

    // Mostly general pairs, some degenerate ones
    task automatic send_random_pair();
        logic signed [31:0] ex, ey, ez, tx, ty, tz;
        int kind, sel;
        kind = $urandom_range(2);
        sel  = $urandom_range(19);
        ex = rand_coord(kind); ey = rand_coord(kind); ez = rand_coord(kind);
        tx = rand_coord(kind); ty = rand_coord(kind); tz = rand_coord(kind);
        if (sel == 0) begin
            tx = ex; ty = ey; tz = ez;
        end else if (sel == 1) begin
            tx = ex; tz = ez;
        end else if (sel == 2) begin
            tx = ex;
        end else if (sel == 3) begin
            tz = ez;
        end
        send_pair(ex, ey, ez, tx, ty, tz);
    endtask

    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_pair(0, 0, 0, 0, 0, 0);
        send_pair(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_pair(5, 32'sh7fffffff, -7, 5, 32'sh80000000, -7);
        send_pair(5, 32'sh80000000, -7, 5, 32'sh7fffffff, -7);
        send_pair(1, 0, 0, 0, 0, 0);
        send_pair(0, 0, 1, 0, 0, 0);
        send_pair(0, 0, 0, 1, 0, 0);
        send_pair(0, 1, 1, 0, 0, 0);
        send_pair(32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0);
        send_pair(32'sh80000000, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_pair(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send_pair(1, 1, 1, 0, 0, 0);
        send_pair(3, 4, 0, 0, 0, 0);
        send_pair(-32'sd65536, 32'sd65536, 32'sd131072, 0, 0, 0);
        send_pair(32'shffffffff, 32'sh55555555, 32'shaaaaaaaa, 0, 0, 0);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct; recv_stall_pct = stall_pct;
        repeat (n) send_random_pair();
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input
    task automatic test_backpressure();
        send_idle_pct = 0; recv_stall_pct = 0;
        recv_hold = 300;
        repeat (120) send_random_pair();
    endtask

    // Sender pauses until every result has drained, then resumes
    task automatic test_drain_pause();
        send_idle_pct = 0; recv_stall_pct = 20;
        i_valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (40) send_random_pair();
    endtask

    // Receiver ready, with long hold-off when requested
    always @(posedge i_clk) begin
        if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            n_errors++;
            $display("%0t %s: expected %0d actual %0d", $time, name,
                     $signed(exp_v), $signed(act_v));
        end
    endtask

    // Compare each result beat with the oldest expected basis
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid && i_ready) begin
            if (basis_q.size() == 0) begin
                n_errors++;
                $display("%0t unexpected result beat, status %0d", $time, o_basis_status);
            end else begin
                e = basis_q.pop_front();
                check_field("right_x", e.rx, o_right_x);
                check_field("right_y", e.ry, o_right_y);
                check_field("right_z", e.rz, o_right_z);
                check_field("up_x", e.ux, o_up_x);
                check_field("up_y", e.uy, o_up_y);
                check_field("up_z", e.uz, o_up_z);
                check_field("fwd_x", e.fx, o_fwd_x);
                check_field("fwd_y", e.fy, o_fwd_y);
                check_field("fwd_z", e.fz, o_fwd_z);
                check_field("status", 32'(e.st), 32'(o_basis_status));
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("look_at_camera_basis: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 45, 0);
        test_random(300, 0, 45);
        test_random(300, 31, 31);
        test_backpressure();
        test_drain_pause();
        i_valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) $display("look_at_camera_basis: match");
        else $display("look_at_camera_basis: mismatch");
        $finish;
    end

endmodule
